// ===== src/barycentric_weights_macros.svh =====
// Assertion macros shared by the barycentric weight block.
// Depends on nothing; included by modules that assert.
`ifndef BARYCENTRIC_WEIGHTS_MACROS_SVH
`define BARYCENTRIC_WEIGHTS_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define BW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/bw_pkg.sv =====
// Package for the barycentric weight block: widths, payload types, constants.
// Depends on nothing.
`timescale 1ns / 1ps
package bw_pkg;
  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int WBits     = 32;
  localparam int CrossBits = 2 * CoordBits + 3;      // cross product width
  localparam int NumBits   = CrossBits + FracBits;   // scaled numerator
  localparam int QBits     = NumBits;                // quotient width
  localparam int DivSteps  = NumBits;                // one bit per stage
  localparam int RemBits   = CrossBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] ax, ay, bx, by, cx, cy, px, py;
  } bw_in_t;

  typedef struct packed {
    logic signed [WBits-1:0] weight_alpha;
    logic signed [WBits-1:0] weight_beta;
    logic signed [WBits-1:0] weight_gamma;
    logic                    degenerate;
  } bw_out_t;

  localparam logic signed [WBits+1:0] WMax = (WBits+2)'(64'sd2147483647);
  localparam logic signed [WBits+1:0] WMin = -(WBits+2)'(64'sd2147483648);
  localparam logic signed [WBits+1:0] One  = (WBits+2)'(1) <<< FracBits;
endpackage

// ===== src/bw_if.sv =====
// Valid/ready stream interfaces for the barycentric weight block.
// Depends on bw_pkg.
`timescale 1ns / 1ps
interface bw_in_if;
  import bw_pkg::*;
  logic   valid;
  logic   ready;
  bw_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bw_out_if;
  import bw_pkg::*;
  logic    valid;
  logic    ready;
  bw_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bw_cross.sv =====
// Cross product front end: differences, then registered products and sums.
// Depends on bw_pkg.
`timescale 1ns / 1ps
module bw_cross (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  bw_pkg::bw_in_t                  in_i,
  output logic                            vld_o,
  output logic signed [bw_pkg::CrossBits-1:0] area_o,
  output logic signed [bw_pkg::CrossBits-1:0] na_o,
  output logic signed [bw_pkg::CrossBits-1:0] nb_o
);
  import bw_pkg::*;
  localparam int DB = CoordBits + 1;
  localparam int PB = 2 * DB;

  logic signed [DB-1:0] abx_q, aby_q, bcx_q, bcy_q, acx_q, acy_q, apx_q, apy_q, bpx_q, bpy_q;
  logic signed [PB-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [CrossBits-1:0] area_q, na_q, nb_q;
  logic v0_q, v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i; v1_q <= v0_q; v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abx_q <= DB'(in_i.bx) - DB'(in_i.ax);
      aby_q <= DB'(in_i.by) - DB'(in_i.ay);
      bcx_q <= DB'(in_i.cx) - DB'(in_i.bx);
      bcy_q <= DB'(in_i.cy) - DB'(in_i.by);
      acx_q <= DB'(in_i.cx) - DB'(in_i.ax);
      acy_q <= DB'(in_i.cy) - DB'(in_i.ay);
      apx_q <= DB'(in_i.px) - DB'(in_i.ax);
      apy_q <= DB'(in_i.py) - DB'(in_i.ay);
      bpx_q <= DB'(in_i.px) - DB'(in_i.bx);
      bpy_q <= DB'(in_i.py) - DB'(in_i.by);
      p0_q <= abx_q * acy_q;
      p1_q <= aby_q * acx_q;
      p2_q <= bcx_q * bpy_q;
      p3_q <= bpx_q * bcy_q;
      p4_q <= apx_q * acy_q;
      p5_q <= acx_q * apy_q;
      area_q <= CrossBits'(p0_q) - CrossBits'(p1_q);
      na_q   <= CrossBits'(p2_q) - CrossBits'(p3_q);
      nb_q   <= CrossBits'(p4_q) - CrossBits'(p5_q);
    end
  end

  assign vld_o  = v2_q;
  assign area_o = area_q;
  assign na_o   = na_q;
  assign nb_o   = nb_q;
endmodule

// ===== src/bw_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding.
// Produces |num|*2^F / |den| rounded half away from zero and the sign.
// Depends on bw_pkg.
`timescale 1ns / 1ps
module bw_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic signed [bw_pkg::CrossBits-1:0] num_i,
  input  logic signed [bw_pkg::CrossBits-1:0] den_i,
  output logic                                vld_o,
  output logic                                neg_o,
  output logic [bw_pkg::QBits:0]              mag_o
);
  import bw_pkg::*;

  logic [DivSteps:0]               v_q;
  logic [DivSteps:0]               neg_q;
  logic [CrossBits-1:0]            d_q [DivSteps+1];
  logic [NumBits-1:0]              n_q [DivSteps+1];
  logic [RemBits-1:0]              r_q [DivSteps+1];
  logic [QBits-1:0]                q_q [DivSteps+1];
  logic [QBits:0]                  mag_q;
  logic                            vo_q, nego_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0; vo_q <= 1'b0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps-1:0], vld_i};
      vo_q <= v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= (num_i < 0) != (den_i < 0);
      d_q[0] <= den_i[CrossBits-1] ? CrossBits'(-den_i) : CrossBits'(den_i);
      n_q[0] <= {(num_i[CrossBits-1] ? CrossBits'(-num_i) : CrossBits'(num_i)),
                 {FracBits{1'b0}}};
      r_q[0] <= '0;
      q_q[0] <= '0;
      for (int s = 0; s < DivSteps; s++) begin
        logic [RemBits-1:0] t;
        t = {r_q[s][RemBits-2:0], n_q[s][NumBits-1]};
        neg_q[s+1] <= neg_q[s];
        d_q[s+1]   <= d_q[s];
        n_q[s+1]   <= {n_q[s][NumBits-2:0], 1'b0};
        if (t >= {1'b0, d_q[s]}) begin
          r_q[s+1] <= t - {1'b0, d_q[s]};
          q_q[s+1] <= {q_q[s][QBits-2:0], 1'b1};
        end else begin
          r_q[s+1] <= t;
          q_q[s+1] <= {q_q[s][QBits-2:0], 1'b0};
        end
      end
      // round half away from zero on magnitude
      mag_q  <= {1'b0, q_q[DivSteps]} +
                (QBits+1)'({r_q[DivSteps], 1'b0} >= {1'b0, d_q[DivSteps], 1'b0} >> 1 ?
                ({r_q[DivSteps], 1'b0} >= {2'b0, d_q[DivSteps]}) : 1'b0);
      nego_q <= neg_q[DivSteps];
    end
  end

  assign vld_o = vo_q;
  assign neg_o = nego_q;
  assign mag_o = mag_q;
endmodule

// ===== src/barycentric_weights.sv =====
// Top level of the barycentric weight block: cross products, dividers, output.
// Depends on bw_pkg, bw_if, bw_cross, bw_div and the assertion macros.
//
// Usage: one transaction on in_if carries a triangle A, B, C and a query point
// P, all signed Q12.4. One transaction on out_if returns weights alpha, beta,
// gamma (signed Q16.16, saturated) and a degenerate flag set when the doubled
// area is zero, in which case all weights are zero.
// Throughput: one transaction per cycle; every pipeline stage advances on any
// cycle the output register is empty or being drained.
// Pipeline: cross products, then the divider pipeline (operand set-up, then one
// quotient bit per stage), then rounding and saturation / output. The accepting
// edge loads the first of these 57 stages.
// Reset clears all valid bits; payload registers keep garbage until filled.
// When the receiver stalls, the whole pipeline holds, ready drops, and the
// pending result stays on out_if until taken. Nothing is lost or repeated.
`timescale 1ns / 1ps
`include "barycentric_weights_macros.svh"
module barycentric_weights (
  input  logic     clk_i,
  input  logic     rst_ni,
  bw_in_if.sink    in_if,
  bw_out_if.source out_if
);
  import bw_pkg::*;

  logic en;
  logic cv;
  logic signed [CrossBits-1:0] area, na, nb;
  logic va, vb, nga, ngb;
  logic [QBits:0] ma, mb;
  logic [DivSteps+1:0] dz_q;     // zero-area flag travels beside the dividers
  logic out_v_q;
  bw_out_t out_q, out_d;
  logic signed [WBits+1:0] sa, sb, g;

  // advance the pipe when the output slot is free or being taken
  assign en = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  bw_cross u_cross (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_if.valid), .in_i(in_if.data),
    .vld_o(cv), .area_o(area), .na_o(na), .nb_o(nb)
  );

  // a zero divisor is replaced by one; the result is dropped later
  bw_div u_div_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cv), .num_i(na),
    .den_i(area == '0 ? CrossBits'(1) : area),
    .vld_o(va), .neg_o(nga), .mag_o(ma)
  );
  bw_div u_div_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cv), .num_i(nb),
    .den_i(area == '0 ? CrossBits'(1) : area),
    .vld_o(vb), .neg_o(ngb), .mag_o(mb)
  );

  always_ff @(posedge clk_i) begin
    if (en) dz_q <= {dz_q[DivSteps:0], area == '0};
  end

  // saturate the magnitude with its sign into the 32-bit range
  function automatic logic signed [WBits+1:0] sat(input logic n, input logic [QBits:0] m);
    logic signed [WBits+1:0] r;
    r = '0;
    if (n) r = (m > (QBits+1)'(64'd2147483648)) ? WMin : -(WBits+2)'(m);
    else   r = (m > (QBits+1)'(64'd2147483647)) ? WMax : (WBits+2)'(m);
    return r;
  endfunction

  always_comb begin
    sa = sat(nga, ma);
    sb = sat(ngb, mb);
    g  = One - sa - sb;
    if (g > WMax) g = WMax;
    if (g < WMin) g = WMin;
    out_d.degenerate   = dz_q[DivSteps+1];
    out_d.weight_alpha = out_d.degenerate ? '0 : WBits'(sa);
    out_d.weight_beta  = out_d.degenerate ? '0 : WBits'(sb);
    out_d.weight_gamma = out_d.degenerate ? '0 : WBits'(g);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= va;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  `BW_ASSERT_IMP(a_div_lockstep, clk_i, rst_ni, 1'b1, va == vb)
  `BW_ASSERT_NXT(a_hold_stall, clk_i, rst_ni, out_v_q && !out_if.ready, out_v_q && $stable(out_q))
  `BW_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, out_v_q && out_q.degenerate,
                 out_q.weight_alpha == '0 && out_q.weight_gamma == '0)
endmodule

// ===== sim/tb_barycentric_weights.sv =====
// Testbench for barycentric_weights: drives triangles and query points, predicts weights.
// Depends on bw_pkg, bw_if and the barycentric_weights RTL.
`timescale 1ns / 1ps

// Holds the expected weight sets in acceptance order and compares results.
class weight_scoreboard;
  bw_pkg::bw_out_t weights_q[$];
  int unsigned     n_err;

  function new();
    n_err = 0;
  endfunction

  // Saturate to the signed 32-bit weight range.
  static function longint clamp_w(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // num * 2^16 / den, rounded half away from zero, saturated; den is nonzero.
  static function longint scaled_quot(longint num, longint den);
    bit              neg;
    longint unsigned n, d, q, r;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (q >= 64'h1_0000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
    for (int i = 0; i < bw_pkg::FracBits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if ((r << 1) >= d) q = q + 1;
    if (neg) begin
      if (q > 64'd2147483648) return -64'sd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) return 64'sd2147483647;
    return longint'(q);
  endfunction

  // Note an accepted triangle and queue its expected weights.
  function void note_input(bw_pkg::bw_in_t t);
    longint          ax, ay, bx, by, cx, cy, px, py, area, na, nb, wa, wb, wg;
    bw_pkg::bw_out_t w;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by;
    cx = t.cx; cy = t.cy; px = t.px; py = t.py;
    area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    na = (cx - bx) * (py - by) - (px - bx) * (cy - by);
    nb = (px - ax) * (cy - ay) - (cx - ax) * (py - ay);
    w = '0;
    if (area == 0) begin
      w.degenerate = 1'b1;
    end else begin
      wa = scaled_quot(na, area);
      wb = scaled_quot(nb, area);
      wg = clamp_w((64'sd1 <<< bw_pkg::FracBits) - wa - wb);
      w.weight_alpha = wa[31:0];
      w.weight_beta  = wb[31:0];
      w.weight_gamma = wg[31:0];
    end
    weights_q.push_back(w);
  endfunction

  function void check_result(bw_pkg::bw_out_t got);
    bw_pkg::bw_out_t exp_w;
    if (weights_q.size() == 0) begin
      $error("unexpected result transaction");
      n_err++;
      return;
    end
    exp_w = weights_q.pop_front();
    if (got.weight_alpha !== exp_w.weight_alpha) begin
      $error("weight_alpha expected %0d got %0d", exp_w.weight_alpha, got.weight_alpha);
      n_err++;
    end
    if (got.weight_beta !== exp_w.weight_beta) begin
      $error("weight_beta expected %0d got %0d", exp_w.weight_beta, got.weight_beta);
      n_err++;
    end
    if (got.weight_gamma !== exp_w.weight_gamma) begin
      $error("weight_gamma expected %0d got %0d", exp_w.weight_gamma, got.weight_gamma);
      n_err++;
    end
    if (got.degenerate !== exp_w.degenerate) begin
      $error("degenerate expected %0b got %0b", exp_w.degenerate, got.degenerate);
      n_err++;
    end
  endfunction
endclass

module tb_barycentric_weights;
  import bw_pkg::*;

  localparam int RandItems  = 600;
  localparam int StallLimit = 5000;   // idle cycles before giving up
  localparam int DrainWait  = 80;     // beyond the 57-stage pipeline

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bw_in_if  in_if ();
  bw_out_if out_if ();

  barycentric_weights u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  weight_scoreboard weights_sb = new();
  bit     calm_phase;   // set during a stretch with no idling on either side
  bit     send_done;
  int     idle_cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Sample both channels at the rising edge; score accepted transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) weights_sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) weights_sb.check_result(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
  end

  // Receiver: stall at random about 29 times in a hundred, never during the calm stretch.
  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= calm_phase || ($urandom_range(99) >= 29);
  end

  // Offer one triangle and hold it until accepted, with an optional leading gap.
  task automatic send_tri(input bw_in_t t);
    while (!calm_phase && $urandom_range(99) < 29) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly real triangles with the point near them; some collinear, thin slivers and random noise.
  function automatic bw_in_t random_tri();
    bw_in_t t;
    int     span, mode;
    mode = $urandom_range(9);
    span = (mode < 3) ? 256 : (mode < 6) ? 4096 : 32767;
    t.ax = 16'($urandom_range(2 * span)) - 16'(span);
    t.ay = 16'($urandom_range(2 * span)) - 16'(span);
    t.bx = 16'($urandom_range(2 * span)) - 16'(span);
    t.by = 16'($urandom_range(2 * span)) - 16'(span);
    t.cx = 16'($urandom_range(2 * span)) - 16'(span);
    t.cy = 16'($urandom_range(2 * span)) - 16'(span);
    t.px = 16'($urandom_range(2 * span)) - 16'(span);
    t.py = 16'($urandom_range(2 * span)) - 16'(span);
    if (mode == 6) begin
      // collinear: C on the line through A and B
      t.cx = 16'(t.ax + 2 * (t.bx - t.ax));
      t.cy = 16'(t.ay + 2 * (t.by - t.ay));
    end else if (mode == 7) begin
      // thin sliver: huge weights, saturation
      t.cx = t.bx + 16'd1;
      t.cy = t.by;
      t.px = pick_coord();
      t.py = pick_coord();
    end else if (mode >= 8) begin
      t = {pick_coord(), pick_coord(), pick_coord(), pick_coord(),
           pick_coord(), pick_coord(), pick_coord(), pick_coord()};
    end
    return t;
  endfunction

  initial begin
    bw_in_t t;
    calm_phase = 1'b0;
    send_done  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    // Directed: unit triangle, vertices as query points, degenerate cases, extremes.
    send_tri('{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd4, 16'sd4});
    send_tri('{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0});
    send_tri('{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd0});
    send_tri('{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd16});
    send_tri('{16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd0, 16'sd5, 16'sd3});
    send_tri('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd1, 16'sd1});
    send_tri('{16'sd0, 16'sd0, 16'sd8, 16'sd8, 16'sd16, 16'sd16, 16'sd3, -16'sd3});
    send_tri('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
               16'sh7FFF, 16'sh7FFF});
    send_tri('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
               16'sh8000, 16'sh8000});
    send_tri('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1,
               16'sh7FFF, 16'sh8000});
    send_tri('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1,
               16'sh8000, 16'sh7FFF});
    send_tri('{16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd2, 16'sd1, 16'sd0});
    send_tri('{16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd1});
    send_tri('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});
    send_tri('{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh0F0F, 16'shF0F0,
               16'sh3333, 16'shCCCC});
    // Random part; a calm stretch with no idling sits in the middle.
    for (int i = 0; i < RandItems; i++) begin
      calm_phase = (i >= 250 && i < 350);
      send_tri(random_tri());
    end
    calm_phase = 1'b0;
    in_if.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Run end: drain, then report; watchdog on cycles with no transaction.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
      if (send_done && weights_sb.weights_q.size() == 0) begin
        repeat (DrainWait) @(posedge clk_i);
        if (weights_sb.n_err == 0 && weights_sb.weights_q.size() == 0) begin
          $display("simulation ok");
        end else begin
          $display("simulation failed");
        end
        $finish;
      end
    end
  end
endmodule

// ===== files.f =====
+incdir+src
src/bw_pkg.sv
src/bw_if.sv
src/bw_cross.sv
src/bw_div.sv
src/barycentric_weights.sv
sim/tb_barycentric_weights.sv
